[rtl/iplpr_pkg.sv]
// Shared types and constants of the IPv4 longest-prefix router.
// No dependencies; every other file of the block but iplpr_ram refers to this package.
`default_nettype none

package iplpr_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned IFACE_W = 3;
  localparam int unsigned TTL_W   = 8;
  localparam int unsigned STAT_W  = 3;

  typedef enum logic [STAT_W-1:0] {
    ST_FORWARDED   = 3'd0,
    ST_TTL_EXPIRED = 3'd1,
    ST_NO_ROUTE    = 3'd2,
    ST_ADDED       = 3'd3,
    ST_FULL        = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_e;

  // One request as it enters the block.
  typedef struct packed {
    logic               func;
    logic [ADDR_W-1:0]  add_prefix;
    logic [LEN_W-1:0]   prefix_len;
    logic               has_next_hop;
    logic [ADDR_W-1:0]  gateway_ip;
    logic [IFACE_W-1:0] iface_index;
    logic [ADDR_W-1:0]  dest_ip;
    logic [TTL_W-1:0]   ttl_in;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [IFACE_W-1:0] out_iface;
    logic [ADDR_W-1:0]  hop_ip;
    logic [TTL_W-1:0]   ttl_out;
  } rsp_t;

  // One stored route, as laid out in the table RAM.
  typedef struct packed {
    logic [ADDR_W-1:0]  prefix;
    logic [LEN_W-1:0]   len;
    logic               has_hop;
    logic [ADDR_W-1:0]  hop;
    logic [IFACE_W-1:0] iface;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic    accept;
    logic    set_code;
    status_e code;
    logic    write_entry;
    logic    scan_read;
    logic    load_result;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_add;
    logic tbl_full;
    logic tbl_empty;
    logic ttl_expired;
    logic scan_last;
    logic out_free;
  } sts_t;

  // Top len bits set, len from 0 to 32.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] ones;
    ones = '1;
    return ~(ones >> len);
  endfunction

endpackage

`default_nettype wire

[rtl/iplpr_if.sv]
// Valid/ready channel interfaces for the router's request and response.
// Depends on iplpr_pkg for field widths and the status type.
`default_nettype none

interface iplpr_req_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic [iplpr_pkg::ADDR_W-1:0]      add_prefix;
  logic [iplpr_pkg::LEN_W-1:0]       prefix_len;
  logic                              has_next_hop;
  logic [iplpr_pkg::ADDR_W-1:0]      gateway_ip;
  logic [iplpr_pkg::IFACE_W-1:0]     iface_index;
  logic [iplpr_pkg::ADDR_W-1:0]      dest_ip;
  logic [iplpr_pkg::TTL_W-1:0]       ttl_in;

  modport source (
    output valid, func, add_prefix, prefix_len, has_next_hop, gateway_ip,
           iface_index, dest_ip, ttl_in,
    input  ready
  );
  modport sink (
    input  valid, func, add_prefix, prefix_len, has_next_hop, gateway_ip,
           iface_index, dest_ip, ttl_in,
    output ready
  );
endinterface

interface iplpr_rsp_if;
  logic                              valid;
  logic                              ready;
  iplpr_pkg::status_e                status;
  logic [iplpr_pkg::IFACE_W-1:0]     out_iface;
  logic [iplpr_pkg::ADDR_W-1:0]      hop_ip;
  logic [iplpr_pkg::TTL_W-1:0]       ttl_out;

  modport source (
    output valid, status, out_iface, hop_ip, ttl_out,
    input  ready
  );
  modport sink (
    input  valid, status, out_iface, hop_ip, ttl_out,
    output ready
  );
endinterface

`default_nettype wire

[rtl/iplpr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module iplpr_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/iplpr_ctrl.sv]
// Sequencing controller of the router: accepts a request, decides its kind,
// steps the table scan and hands the result off. Depends on iplpr_pkg.
`default_nettype none

module iplpr_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            req_valid_i,
  output      logic            req_ready_o,
  input  wire iplpr_pkg::sts_t sts_i,
  output      iplpr_pkg::cmd_t cmd_o
);

  iplpr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iplpr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    cmd_o.code  = iplpr_pkg::ST_NO_ROUTE;
    unique case (state_q)
      iplpr_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = iplpr_pkg::S_DECIDE;
        end
      end
      iplpr_pkg::S_DECIDE: begin
        cmd_o.set_code = 1'b1;
        state_d        = iplpr_pkg::S_DONE;
        priority if (sts_i.is_add) begin
          if (sts_i.tbl_full) begin
            cmd_o.code = iplpr_pkg::ST_FULL;
          end else begin
            cmd_o.code        = iplpr_pkg::ST_ADDED;
            cmd_o.write_entry = 1'b1;
          end
        end else if (sts_i.ttl_expired) begin
          cmd_o.code = iplpr_pkg::ST_TTL_EXPIRED;
        end else if (!sts_i.tbl_empty) begin
          // first table read goes out right away
          cmd_o.scan_read = 1'b1;
          state_d = sts_i.scan_last ? iplpr_pkg::S_DRAIN : iplpr_pkg::S_SCAN;
        end else begin
          state_d = iplpr_pkg::S_DONE;
        end
      end
      iplpr_pkg::S_SCAN: begin
        cmd_o.scan_read = 1'b1;
        if (sts_i.scan_last) begin
          state_d = iplpr_pkg::S_DRAIN;
        end
      end
      iplpr_pkg::S_DRAIN: begin
        state_d = iplpr_pkg::S_DONE;
      end
      iplpr_pkg::S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = iplpr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = iplpr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/iplpr_dp.sv]
// Datapath of the router: request register, route table RAM, entry count,
// scan index, best-match tracking and the output register.
// Depends on iplpr_pkg and iplpr_ram.
`default_nettype none

module iplpr_dp #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire iplpr_pkg::req_t req_i,
  input  wire iplpr_pkg::cmd_t cmd_i,
  output      iplpr_pkg::sts_t sts_o,
  output      logic            rsp_valid_o,
  input  wire logic            rsp_ready_i,
  output      iplpr_pkg::rsp_t rsp_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = $bits(iplpr_pkg::entry_t);

  iplpr_pkg::req_t     req_q;
  iplpr_pkg::status_e  code_q;
  logic [CW-1:0]       count_q;
  logic [AW-1:0]       idx_q;
  logic                pend_q;
  logic                found_q;
  logic [iplpr_pkg::LEN_W-1:0]   best_len_q;
  logic                          best_has_hop_q;
  logic [iplpr_pkg::ADDR_W-1:0]  best_hop_q;
  logic [iplpr_pkg::IFACE_W-1:0] best_iface_q;
  logic                rsp_valid_q;
  iplpr_pkg::rsp_t     rsp_q;

  iplpr_pkg::entry_t   wr_entry;
  iplpr_pkg::entry_t   rd_entry;
  logic [EW-1:0]       rd_data;
  logic [iplpr_pkg::ADDR_W-1:0] rd_mask;
  logic                hit;
  logic                take;

  // Saturate the prefix length to the address width when storing.
  always_comb begin
    wr_entry.prefix  = req_q.add_prefix;
    wr_entry.len     = (req_q.prefix_len > iplpr_pkg::LEN_W'(iplpr_pkg::ADDR_W)) ?
                       iplpr_pkg::LEN_W'(iplpr_pkg::ADDR_W) : req_q.prefix_len;
    wr_entry.has_hop = req_q.has_next_hop;
    wr_entry.hop     = req_q.gateway_ip;
    wr_entry.iface   = req_q.iface_index;
  end

  iplpr_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write_entry),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.scan_read),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  assign rd_entry = iplpr_pkg::entry_t'(rd_data);
  assign rd_mask  = iplpr_pkg::prefix_mask(rd_entry.len);
  assign hit      = ((rd_entry.prefix ^ req_q.dest_ip) & rd_mask) == '0;
  // later entry wins a tie on length
  assign take     = pend_q && hit && (!found_q || (rd_entry.len >= best_len_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= req_i;
    end
    if (cmd_i.set_code) begin
      code_q <= cmd_i.code;
    end
    if (take) begin
      best_len_q     <= rd_entry.len;
      best_has_hop_q <= rd_entry.has_hop;
      best_hop_q     <= rd_entry.hop;
      best_iface_q   <= rd_entry.iface;
    end
    if (cmd_i.load_result) begin
      if ((code_q == iplpr_pkg::ST_NO_ROUTE) && found_q) begin
        rsp_q.status    <= iplpr_pkg::ST_FORWARDED;
        rsp_q.out_iface <= best_iface_q;
        rsp_q.hop_ip    <= best_has_hop_q ? best_hop_q : req_q.dest_ip;
        rsp_q.ttl_out   <= req_q.ttl_in - iplpr_pkg::TTL_W'(1);
      end else begin
        rsp_q.status    <= code_q;
        rsp_q.out_iface <= '0;
        rsp_q.hop_ip    <= '0;
        rsp_q.ttl_out   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.scan_read;
      if (cmd_i.write_entry) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.accept) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.scan_read) begin
          idx_q <= idx_q + AW'(1);
        end
        if (take) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.load_result) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.is_add      = !req_q.func;
    sts_o.tbl_full    = count_q == CW'(TABLE_DEPTH);
    sts_o.tbl_empty   = count_q == '0;
    sts_o.ttl_expired = req_q.ttl_in < iplpr_pkg::TTL_W'(2);
    sts_o.scan_last   = (CW'(idx_q) + CW'(1)) == count_q;
    sts_o.out_free    = !rsp_valid_q || rsp_ready_i;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_entry |-> !sts_o.tbl_full)
    else $error("route written into a full table");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_read |-> (CW'(idx_q) < count_q))
    else $error("scan reads past the last stored route");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_result |-> (!rsp_valid_q || rsp_ready_i))
    else $error("result loaded over an untaken result");

endmodule

`default_nettype wire

[rtl/ipv4_longest_prefix_router.sv]
// IPv4 routing table with longest-prefix match (top level).
// Depends on iplpr_pkg, iplpr_if, iplpr_ctrl, iplpr_dp and iplpr_ram.
//
// Usage:
//   req_i carries one request per valid/ready handshake. func=0 appends a
//   route (prefix, length, optional gateway, interface); func=1 routes a
//   datagram by dest_ip and ttl_in. rsp_o returns exactly one response per
//   request, in request order: status, out_iface, hop_ip, ttl_out (the last
//   three are zero unless the status is forwarded).
//   Timing: an add, a dropped datagram (TTL of 1 or less) or a lookup in an
//   empty table goes through the decide and done states to a valid response.
//   A lookup walks the N stored routes one per cycle through the table RAM's
//   single read port and then passes a drain state for the last read. The
//   next request is accepted the cycle after the response is loaded, so no
//   request is taken before the last one's response is loaded.
//   Stall: hold the response in the output register until rsp_o.ready; a
//   following request is still accepted and worked, and only its result
//   waits until the output register frees up.
//   Reset: rst_ni clears the route count and all control state; the route
//   RAM is not cleared since no entry is read before it is written.
`default_nettype none

module ipv4_longest_prefix_router #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  iplpr_req_if.sink   req_i,
  iplpr_rsp_if.source rsp_o
);

  iplpr_pkg::cmd_t cmd;
  iplpr_pkg::sts_t sts;
  iplpr_pkg::req_t req;
  iplpr_pkg::rsp_t rsp;
  logic            req_ready;
  logic            rsp_valid;

  // Gather the request fields into one word for the request register.
  always_comb begin
    req.func         = req_i.func;
    req.add_prefix   = req_i.add_prefix;
    req.prefix_len   = req_i.prefix_len;
    req.has_next_hop = req_i.has_next_hop;
    req.gateway_ip   = req_i.gateway_ip;
    req.iface_index  = req_i.iface_index;
    req.dest_ip      = req_i.dest_ip;
    req.ttl_in       = req_i.ttl_in;
  end

  assign req_i.ready = req_ready;

  // Controller: sequences accept, decide, scan, drain and hand-off.
  iplpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: table RAM, compare and best-match registers, output register.
  iplpr_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (rsp)
  );

  // Drive the response channel straight from the output register.
  assign rsp_o.valid     = rsp_valid;
  assign rsp_o.status    = rsp.status;
  assign rsp_o.out_iface = rsp.out_iface;
  assign rsp_o.hop_ip    = rsp.hop_ip;
  assign rsp_o.ttl_out   = rsp.ttl_out;

endmodule

`default_nettype wire
